[hw/rtl/bfo_pkg.sv]
// Shared types, constants and small functions of the formation offset block.
`default_nettype none

package bfo_pkg;

  localparam int unsigned MAX_POINTS_DEF    = 64;
  localparam int unsigned MAX_FOLLOWERS_DEF = 8;

  localparam int unsigned MAG_W  = 30;
  localparam int unsigned ROOT_W = 31;
  localparam int unsigned UNIT_W = 15;

  localparam logic [30:0]        SPACING_RST = 31'd104858;
  localparam logic [14:0]        COS_RST     = 15'd13421;
  localparam logic [14:0]        SIN_RST     = 15'd9397;
  localparam logic signed [31:0] HEIGHT_RST  = 32'sd0;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_LOAD   = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_SPACING = 2'd0,
    REG_COS     = 2'd1,
    REG_SIN     = 2'd2,
    REG_HEIGHT  = 2'd3
  } reg_e;

  typedef struct packed {
    logic               command;
    logic [5:0]         point_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [6:0]         point_count;
    logic [2:0]         follower_slot;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] value;
  } cfg_item_t;

  // Weight of control point p in three times the tangent at u = j/3.
  function automatic logic signed [4:0] coef(input logic [1:0] j, input logic [1:0] p);
    logic signed [4:0] c;
    case ({j, p})
      4'h0:    c = -5'sd9;
      4'h1:    c = 5'sd9;
      4'h4:    c = -5'sd4;
      4'h6:    c = 5'sd3;
      4'h7:    c = 5'sd1;
      4'h8:    c = -5'sd1;
      4'h9:    c = -5'sd3;
      4'hB:    c = 5'sd4;
      4'hE:    c = -5'sd9;
      4'hF:    c = 5'sd9;
      default: c = 5'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > 37'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -37'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/bfo_chan_if.sv]
// Valid/ready channel carrying one item of a given type.
`default_nettype none

interface bfo_chan_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/bfo_norm.sv]
// Multi-cycle unit: square root of ax^2 + ay^2 and the two unsigned Q1.14 quotients.
`default_nettype none

module bfo_norm (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [bfo_pkg::MAG_W-1:0]   ax_i,
  input  wire logic [bfo_pkg::MAG_W-1:0]   ay_i,
  output logic                             done_o,
  output logic [bfo_pkg::UNIT_W-1:0]       ux_o,
  output logic [bfo_pkg::UNIT_W-1:0]       uy_o
);

  typedef enum logic [4:0] {
    N_IDLE = 5'b00001,
    N_SQ   = 5'b00010,
    N_ROOT = 5'b00100,
    N_PREP = 5'b01000,
    N_DIV  = 5'b10000
  } nstate_e;

  nstate_e state_q, state_d;
  logic [4:0]  cnt_q;
  logic [3:0]  qcnt_q;
  logic        done_q;

  logic [29:0] ax_q, ay_q;
  logic [59:0] sq_q;
  logic [60:0] rad_q;
  logic [61:0] root_q;
  logic [30:0] div_q;
  logic [30:0] remx_q, remy_q;
  logic [14:0] nlx_q, nly_q;
  logic [14:0] qx_q, qy_q;

  logic [61:0] bitv, trial;
  logic        take;
  logic [30:0] rt;
  logic [44:0] numx, numy;
  logic [31:0] tx, ty;
  logic        gex, gey;

  always_comb begin
    bitv  = 62'(1) << {cnt_q, 1'b0};
    trial = root_q + bitv;
    take  = {1'b0, rad_q} >= trial;
    rt    = (root_q[30:0] == '0) ? 31'd1 : root_q[30:0];
    numx  = {1'b0, ax_q, 14'b0} + 45'(rt >> 1);
    numy  = {1'b0, ay_q, 14'b0} + 45'(rt >> 1);
    tx    = {remx_q, nlx_q[qcnt_q]};
    ty    = {remy_q, nly_q[qcnt_q]};
    gex   = tx >= {1'b0, div_q};
    gey   = ty >= {1'b0, div_q};
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      N_IDLE: if (start_i) state_d = N_SQ;
      N_SQ:   state_d = N_ROOT;
      N_ROOT: if (cnt_q == '0) state_d = N_PREP;
      N_PREP: state_d = N_DIV;
      N_DIV:  if (qcnt_q == '0) state_d = N_IDLE;
      default: state_d = N_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      cnt_q   <= '0;
      qcnt_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == N_DIV) && (qcnt_q == '0);
      if (state_q == N_SQ) cnt_q <= 5'd30;
      else if (state_q == N_ROOT) cnt_q <= cnt_q - 5'd1;
      if (state_q == N_PREP) qcnt_q <= 4'd14;
      else if (state_q == N_DIV) qcnt_q <= qcnt_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      N_IDLE: begin
        if (start_i) begin
          ax_q <= ax_i;
          ay_q <= ay_i;
          sq_q <= ax_i * ax_i;
        end
      end
      N_SQ: begin
        rad_q  <= 61'(sq_q) + 61'(ay_q * ay_q);
        root_q <= '0;
      end
      N_ROOT: begin
        if (take) begin
          rad_q  <= 61'({1'b0, rad_q} - trial);
          root_q <= (root_q >> 1) + bitv;
        end else begin
          root_q <= root_q >> 1;
        end
      end
      N_PREP: begin
        div_q  <= rt;
        remx_q <= {1'b0, numx[44:15]};
        remy_q <= {1'b0, numy[44:15]};
        nlx_q  <= numx[14:0];
        nly_q  <= numy[14:0];
        qx_q   <= '0;
        qy_q   <= '0;
      end
      N_DIV: begin
        remx_q <= gex ? 31'(tx - {1'b0, div_q}) : tx[30:0];
        remy_q <= gey ? 31'(ty - {1'b0, div_q}) : ty[30:0];
        qx_q   <= {qx_q[13:0], gex};
        qy_q   <= {qy_q[13:0], gey};
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign ux_o   = qx_q;
  assign uy_o   = qy_q;

endmodule

`default_nettype wire

[hw/rtl/bezier_formation_offset.sv]
// Top level: V-formation follower point from a stored cubic Bezier leader path.
//
//   channel  dir  item         handshake
//   in_i     in   in_item_t    valid/ready, load or query
//   out_o    out  out_item_t   valid/ready, one result per item
//   cfg_i    in   cfg_item_t   valid/ready, register index and value
//
// A load or a rejected query goes from the idle state to the final state, then into
// the output register once that is free. A query runs through the window reads from
// the point memory, range reduction, the bit-serial square root and the 15-step
// divide, the offset products and the hand-off, and then the output register.
// A zero smoothed tangent skips range reduction and normalization. Reset clears the
// control state and the config registers; the point memory holds garbage until
// written. A stalled output holds its item, and the next item is taken meanwhile.
`default_nettype none

module bezier_formation_offset #(
  parameter int unsigned MAX_POINTS    = bfo_pkg::MAX_POINTS_DEF,
  parameter int unsigned MAX_FOLLOWERS = bfo_pkg::MAX_FOLLOWERS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  bfo_chan_if.sink    in_i,
  bfo_chan_if.source  out_o,
  bfo_chan_if.sink    cfg_i
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam logic [10:0] NP = 11'(MAX_POINTS);
  localparam logic [5:0]  MF = 6'(MAX_FOLLOWERS);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_READ  = 8'b0000_0010,
    S_SHIFT = 8'b0000_0100,
    S_NORM  = 8'b0000_1000,
    S_BK    = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_SUM   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [30:0]        spacing_q;
  logic [14:0]        cos_q, sin_q;
  logic signed [31:0] height_q;

  logic [4:0]  step_q;
  logic [1:0]  mi_q;
  logic        rd_vld_q, rd_last_q, out_valid_q;

  logic [95:0] mem [MAX_POINTS];
  logic [95:0] rd_q;
  logic signed [4:0]  rd_coef_q;

  logic [5:0]  c_q;
  logic [6:0]  n_q;
  logic [4:0]  nseg_q;
  logic [33:0] ls_q;
  logic        odd_q, negx_q, negy_q;
  logic signed [41:0] accx_q, accy_q;
  logic [40:0] ax_q, ay_q;
  logic signed [31:0] px_q, py_q, pz_q;
  logic signed [15:0] fx_q, fy_q;
  logic signed [49:0] bk_q, lt_q;
  logic signed [63:0] ox_q, oy_q;
  bfo_pkg::out_item_t res_q, out_q;

  // Accept-side decode.
  logic        in_acc;
  logic [5:0]  idx;
  logic [6:0]  n_sat, nm1;
  logic [13:0] nseg_p;
  logic        load_ok, q_reject;
  logic [5:0]  k6;
  logic [2:0]  level;

  always_comb begin
    in_acc  = in_i.valid && (state_q == S_IDLE);
    idx     = in_i.data.point_index;
    n_sat   = ({4'b0, in_i.data.point_count} > NP) ? NP[6:0] : in_i.data.point_count;
    nm1     = n_sat - 7'd1;
    nseg_p  = 14'(nm1) * 14'd43;
    load_ok = {5'b0, idx} < NP;
    q_reject = (n_sat < 7'd4) || ({1'b0, idx} >= n_sat);
    k6 = {3'b0, in_i.data.follower_slot};
    for (int i = 0; i < 8; i++) begin
      if (k6 >= MF) k6 = k6 - MF;
    end
    level = {1'b0, k6[2:1]} + 3'd1;
  end

  // Window read address and weight.
  logic [2:0]  wi;
  logic [1:0]  pi;
  logic signed [7:0] ws;
  logic [6:0]  wu;
  logic        wvld;
  logic [12:0] seg_p;
  logic [4:0]  seg, seg_max;
  logic [6:0]  base, jraw, raddr7;
  logic [1:0]  jj;
  logic [AW-1:0] raddr;

  always_comb begin
    wi      = step_q[4:2];
    pi      = step_q[1:0];
    ws      = $signed({2'b0, c_q}) - 8'sd2 + $signed({5'b0, wi});
    wu      = ws[6:0];
    wvld    = !ws[7] && (wu < n_q);
    seg_p   = 13'(wu) * 13'd43;
    seg_max = nseg_q - 5'd1;
    seg     = (seg_p[11:7] > seg_max || seg_p[12]) ? seg_max : seg_p[11:7];
    base    = 7'(seg) * 7'd3;
    jraw    = wu - base;
    jj      = (jraw > 7'd3) ? 2'd3 : jraw[1:0];
    raddr7  = (step_q == 5'd20) ? {1'b0, c_q} : base + 7'(pi);
    raddr   = AW'(raddr7);
  end

  // Window accumulation.
  logic signed [31:0] rdx, rdy;
  logic signed [36:0] prodx, prody;
  logic signed [41:0] negax, negay;

  always_comb begin
    rdx   = rd_q[31:0];
    rdy   = rd_q[63:32];
    prodx = 37'(rd_coef_q) * 37'(rdx);
    prody = 37'(rd_coef_q) * 37'(rdy);
    negax = -accx_q;
    negay = -accy_q;
  end

  // Normalization unit.
  logic        norm_start, norm_done;
  logic [14:0] ux, uy;

  assign norm_start = (state_q == S_SHIFT) && (ax_q[40:30] == '0) && (ay_q[40:30] == '0);

  bfo_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .ax_i    (ax_q[29:0]),
    .ay_i    (ay_q[29:0]),
    .done_o  (norm_done),
    .ux_o    (ux),
    .uy_o    (uy)
  );

  // Offset products and final sums.
  logic signed [15:0] fsel;
  logic signed [49:0] bsel;
  logic signed [65:0] prod;
  logic signed [63:0] rx, ry;
  logic signed [36:0] sumx, sumy, sumz;

  always_comb begin
    fsel = (mi_q == 2'd1 || mi_q == 2'd2) ? fy_q : fx_q;
    bsel = mi_q[0] ? lt_q : bk_q;
    prod = 66'(fsel) * 66'(bsel);
    rx   = ox_q + 64'sd134217728;
    ry   = oy_q + 64'sd134217728;
    sumx = 37'(px_q) + 37'($signed(rx[63:28]));
    sumy = 37'(py_q) + 37'($signed(ry[63:28]));
    sumz = 37'(pz_q) + 37'(height_q);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_i.data.command == bfo_pkg::CMD_QUERY && !q_reject) state_d = S_READ;
          else state_d = S_FIN;
        end
      end
      S_READ: begin
        if (rd_last_q) begin
          state_d = (accx_q == '0 && accy_q == '0) ? S_BK : S_SHIFT;
        end
      end
      S_SHIFT: if (norm_start) state_d = S_NORM;
      S_NORM:  if (norm_done) state_d = S_BK;
      S_BK:    state_d = S_MUL;
      S_MUL:   if (mi_q == 2'd3) state_d = S_SUM;
      S_SUM:   state_d = S_FIN;
      S_FIN:   if (!out_valid_q || out_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      mi_q        <= '0;
      rd_vld_q    <= 1'b0;
      rd_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
      spacing_q   <= bfo_pkg::SPACING_RST;
      cos_q       <= bfo_pkg::COS_RST;
      sin_q       <= bfo_pkg::SIN_RST;
      height_q    <= bfo_pkg::HEIGHT_RST;
    end else begin
      state_q   <= state_d;
      rd_vld_q  <= (state_q == S_READ) && (step_q < 5'd20) && wvld;
      rd_last_q <= (state_q == S_READ) && (step_q == 5'd20);
      if (state_q == S_IDLE) step_q <= '0;
      else if (state_q == S_READ && step_q <= 5'd20) step_q <= step_q + 5'd1;
      if (state_q == S_MUL) mi_q <= mi_q + 2'd1;
      else mi_q <= '0;
      if (state_q == S_FIN && (!out_valid_q || out_o.ready)) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
      if (cfg_i.valid) begin
        unique case (cfg_i.data.index)
          bfo_pkg::REG_SPACING: spacing_q <= cfg_i.data.value[30:0];
          bfo_pkg::REG_COS:     cos_q     <= cfg_i.data.value[14:0];
          bfo_pkg::REG_SIN:     sin_q     <= cfg_i.data.value[14:0];
          bfo_pkg::REG_HEIGHT:  height_q  <= $signed(cfg_i.data.value);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.data.command == bfo_pkg::CMD_LOAD && load_ok) begin
      mem[AW'(idx)] <= {in_i.data.pos_z, in_i.data.pos_y, in_i.data.pos_x};
    end
    rd_q      <= mem[raddr];
    rd_coef_q <= bfo_pkg::coef(jj, pi);
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          c_q    <= idx;
          n_q    <= n_sat;
          nseg_q <= nseg_p[11:7];
          ls_q   <= 34'(spacing_q) * 34'(level);
          odd_q  <= k6[0];
          accx_q <= '0;
          accy_q <= '0;
          res_q.out_x <= '0;
          res_q.out_y <= '0;
          res_q.out_z <= '0;
          if (in_i.data.command == bfo_pkg::CMD_LOAD) begin
            res_q.status <= load_ok ? bfo_pkg::ST_LOAD : bfo_pkg::ST_REJECT;
          end else begin
            res_q.status <= bfo_pkg::ST_REJECT;
          end
        end
      end
      S_READ: begin
        if (rd_vld_q) begin
          accx_q <= accx_q + 42'(prodx);
          accy_q <= accy_q + 42'(prody);
        end
        if (rd_last_q) begin
          px_q   <= rdx;
          py_q   <= rdy;
          pz_q   <= rd_q[95:64];
          ax_q   <= accx_q[41] ? negax[40:0] : accx_q[40:0];
          ay_q   <= accy_q[41] ? negay[40:0] : accy_q[40:0];
          negx_q <= accx_q[41];
          negy_q <= accy_q[41];
          fx_q   <= 16'sd16384;
          fy_q   <= 16'sd0;
        end
      end
      S_SHIFT: begin
        if (!norm_start) begin
          ax_q <= ax_q >> 1;
          ay_q <= ay_q >> 1;
        end
      end
      S_NORM: begin
        if (norm_done) begin
          fx_q <= negx_q ? -$signed({1'b0, ux}) : $signed({1'b0, ux});
          fy_q <= negy_q ? -$signed({1'b0, uy}) : $signed({1'b0, uy});
        end
      end
      S_BK: begin
        bk_q <= $signed({1'b0, 49'(ls_q) * 49'(cos_q)});
        lt_q <= odd_q ? -$signed({1'b0, 49'(ls_q) * 49'(sin_q)})
                      : $signed({1'b0, 49'(ls_q) * 49'(sin_q)});
      end
      S_MUL: begin
        unique case (mi_q)
          2'd0: ox_q <= -prod[63:0];
          2'd1: ox_q <= ox_q - prod[63:0];
          2'd2: oy_q <= -prod[63:0];
          2'd3: oy_q <= oy_q + prod[63:0];
          default: ;
        endcase
      end
      S_SUM: begin
        res_q.out_x  <= bfo_pkg::sat32(sumx);
        res_q.out_y  <= bfo_pkg::sat32(sumy);
        res_q.out_z  <= bfo_pkg::sat32(sumz);
        res_q.status <= bfo_pkg::ST_DONE;
      end
      S_FIN: begin
        if (!out_valid_q || out_o.ready) out_q <= res_q;
      end
      default: ;
    endcase
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("control state is not one-hot");

  a_norm_done_in_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    norm_done |-> state_q == S_NORM) else $error("normalizer finished outside wait state");

  a_last_read_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_last_q |-> state_q == S_READ) else $error("point read returned outside read phase");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= 5'd21) else $error("read step counter overran the window");

endmodule

`default_nettype wire
